// ===== rtl/mfd_pkg.sv =====
// Shared types and constants for the max-flow (Dinic) core.
// Used by mfd_ctrl, mfd_dp and max_flow_dinic_core; depends on nothing.
package mfd_pkg;

	// Fixed port widths
	localparam int NODE_W   = 6;
	localparam int IN_CAP_W = 32;
	localparam int FLOW_W   = 40;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 32;

	localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

	// Register indexes on the configuration port
	localparam logic REG_SOURCE = 1'b0;
	localparam logic REG_SINK   = 1'b1;

	// Datapath operations, one per controller step
	typedef enum logic [4:0] {
		OP_IDLE,
		OP_REV,
		OP_START,
		OP_LCLR,
		OP_LINIT,
		OP_BQCHK,
		OP_BQRD,
		OP_BLV,
		OP_BSCAN,
		OP_BARC,
		OP_BLW,
		OP_BDONE_RD,
		OP_BDONE,
		OP_PCLR,
		OP_DINIT,
		OP_DTOP,
		OP_DRD,
		OP_DSCAN,
		OP_DARC,
		OP_DLW,
		OP_DMISS,
		OP_DPOP0,
		OP_DPOP1,
		OP_DPOP2,
		OP_DPOP3,
		OP_AMIN_S,
		OP_AMIN_A,
		OP_AMIN_R,
		OP_AUP_S,
		OP_AUP_A,
		OP_AUP_W,
		OP_AUP_V
	} op_t;

	typedef struct packed {
		op_t  op;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic in_fire;
		logic last_q;
		logic st_eq;
		logic sweep_last;
		logic q_empty;
		logic scan_end;
		logic arc_ok;
		logic usable;
		logic depth_full;
		logic depth_zero;
		logic t_unr;
		logic v_is_t;
		logic i_last;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/mfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mfd_ctrl.sv =====
// Sequencer for edge loading, level passes, blocking-flow walk and result.
// Depends on mfd_pkg (op_t, cmd_t, status_t).
module mfd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  mfd_pkg::status_t sts,
	output mfd_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_REV, S_START, S_LCLR, S_LINIT, S_BQCHK, S_BQRD, S_BLV,
		S_BSCAN, S_BARC, S_BLW, S_BDONE_RD, S_BDONE, S_PCLR, S_DINIT,
		S_DTOP, S_DRD, S_DSCAN, S_DARC, S_DLW, S_DMISS, S_DPOP0, S_DPOP1,
		S_DPOP2, S_DPOP3, S_AMIN_S, S_AMIN_A, S_AMIN_R, S_AUP_S, S_AUP_A,
		S_AUP_W, S_AUP_V
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next step
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (sts.in_fire) state_d = S_REV;
			S_REV:      state_d = sts.last_q ? S_START : S_IDLE;
			S_START:    state_d = sts.st_eq ? S_IDLE : S_LCLR;
			S_LCLR:     if (sts.sweep_last) state_d = S_LINIT;
			S_LINIT:    state_d = S_BQCHK;
			S_BQCHK:    state_d = sts.q_empty ? S_BDONE_RD : S_BQRD;
			S_BQRD:     state_d = S_BLV;
			S_BLV:      state_d = S_BSCAN;
			S_BSCAN:    state_d = sts.scan_end ? S_BQCHK : S_BARC;
			S_BARC:     state_d = sts.arc_ok ? S_BLW : S_BSCAN;
			S_BLW:      state_d = S_BSCAN;
			S_BDONE_RD: state_d = S_BDONE;
			S_BDONE:    state_d = sts.t_unr ? S_IDLE : S_PCLR;
			S_PCLR:     if (sts.sweep_last) state_d = S_DINIT;
			S_DINIT:    state_d = S_DTOP;
			S_DTOP:     state_d = sts.v_is_t ? S_AMIN_S : S_DRD;
			S_DRD:      state_d = S_DSCAN;
			S_DSCAN:    state_d = sts.scan_end ? S_DMISS : S_DARC;
			S_DARC:     state_d = sts.arc_ok ? S_DLW : S_DSCAN;
			S_DLW: begin
				if (!sts.usable) state_d = S_DSCAN;
				else state_d = sts.depth_full ? S_DPOP0 : S_DTOP;
			end
			S_DMISS:    state_d = sts.depth_zero ? S_LCLR : S_DPOP0;
			S_DPOP0:    state_d = S_DPOP1;
			S_DPOP1:    state_d = S_DPOP2;
			S_DPOP2:    state_d = S_DPOP3;
			S_DPOP3:    state_d = S_DTOP;
			S_AMIN_S:   state_d = S_AMIN_A;
			S_AMIN_A:   state_d = S_AMIN_R;
			S_AMIN_R:   state_d = sts.i_last ? S_AUP_S : S_AMIN_S;
			S_AUP_S:    state_d = S_AUP_A;
			S_AUP_A:    state_d = S_AUP_W;
			S_AUP_W:    state_d = S_AUP_V;
			S_AUP_V:    state_d = sts.i_last ? S_DTOP : S_AUP_S;
			default:    state_d = S_IDLE;
		endcase
		// Hold in place until the result slot frees up
		if ((state_q == S_START && sts.st_eq) || (state_q == S_BDONE && sts.t_unr)) begin
			if (!sts.out_free) state_d = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Issue the datapath operation for the current step
	always_comb begin
		cmd.finish = ((state_q == S_START && sts.st_eq) ||
			(state_q == S_BDONE && sts.t_unr)) && sts.out_free;
		unique case (state_q)
			S_IDLE:     cmd.op = mfd_pkg::OP_IDLE;
			S_REV:      cmd.op = mfd_pkg::OP_REV;
			S_START:    cmd.op = mfd_pkg::OP_START;
			S_LCLR:     cmd.op = mfd_pkg::OP_LCLR;
			S_LINIT:    cmd.op = mfd_pkg::OP_LINIT;
			S_BQCHK:    cmd.op = mfd_pkg::OP_BQCHK;
			S_BQRD:     cmd.op = mfd_pkg::OP_BQRD;
			S_BLV:      cmd.op = mfd_pkg::OP_BLV;
			S_BSCAN:    cmd.op = mfd_pkg::OP_BSCAN;
			S_BARC:     cmd.op = mfd_pkg::OP_BARC;
			S_BLW:      cmd.op = mfd_pkg::OP_BLW;
			S_BDONE_RD: cmd.op = mfd_pkg::OP_BDONE_RD;
			S_BDONE:    cmd.op = mfd_pkg::OP_BDONE;
			S_PCLR:     cmd.op = mfd_pkg::OP_PCLR;
			S_DINIT:    cmd.op = mfd_pkg::OP_DINIT;
			S_DTOP:     cmd.op = mfd_pkg::OP_DTOP;
			S_DRD:      cmd.op = mfd_pkg::OP_DRD;
			S_DSCAN:    cmd.op = mfd_pkg::OP_DSCAN;
			S_DARC:     cmd.op = mfd_pkg::OP_DARC;
			S_DLW:      cmd.op = mfd_pkg::OP_DLW;
			S_DMISS:    cmd.op = mfd_pkg::OP_DMISS;
			S_DPOP0:    cmd.op = mfd_pkg::OP_DPOP0;
			S_DPOP1:    cmd.op = mfd_pkg::OP_DPOP1;
			S_DPOP2:    cmd.op = mfd_pkg::OP_DPOP2;
			S_DPOP3:    cmd.op = mfd_pkg::OP_DPOP3;
			S_AMIN_S:   cmd.op = mfd_pkg::OP_AMIN_S;
			S_AMIN_A:   cmd.op = mfd_pkg::OP_AMIN_A;
			S_AMIN_R:   cmd.op = mfd_pkg::OP_AMIN_R;
			S_AUP_S:    cmd.op = mfd_pkg::OP_AUP_S;
			S_AUP_A:    cmd.op = mfd_pkg::OP_AUP_A;
			S_AUP_W:    cmd.op = mfd_pkg::OP_AUP_W;
			S_AUP_V:    cmd.op = mfd_pkg::OP_AUP_V;
			default:    cmd.op = mfd_pkg::OP_IDLE;
		endcase
	end

endmodule

// ===== rtl/mfd_dp.sv =====
// Datapath: arc, level, pointer, queue and stack memories plus walk registers.
// Depends on mfd_pkg and mfd_ram; driven by mfd_ctrl through cmd_t/status_t.
module mfd_dp #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256,
	parameter int CAP_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mfd_pkg::cmd_t                 cmd,
	output mfd_pkg::status_t              sts,
	input  logic [mfd_pkg::NODE_W-1:0]    src_node,
	input  logic [mfd_pkg::NODE_W-1:0]    snk_node,
	input  logic                          in_valid,
	input  logic [mfd_pkg::NODE_W-1:0]    from_node,
	input  logic [mfd_pkg::NODE_W-1:0]    to_node,
	input  logic [mfd_pkg::IN_CAP_W-1:0]  capacity,
	input  logic                          last_edge,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [mfd_pkg::FLOW_W-1:0]    max_flow,
	output logic                          table_overflow
);

	localparam int NW    = $clog2(MAX_NODES);
	localparam int LW    = NW + 1;
	localparam int SLOTS = 2 * MAX_EDGES;
	localparam int AW    = $clog2(SLOTS);
	localparam int CW    = AW + 1;
	localparam int FW    = mfd_pkg::FLOW_W;
	localparam int SW    = ((FW > CAP_WIDTH) ? FW : CAP_WIDTH) + 1;
	localparam logic [LW-1:0] UNREACHED = '1;

	// Walk and bookkeeping registers
	logic [CW-1:0]        cnt_q;
	logic [FW-1:0]        flow_q;
	logic                 ovf_q;
	logic                 fits_q;
	logic                 last_q;
	logic [NW-1:0]        eu_q;
	logic [NW-1:0]        ew_q;
	logic [NW-1:0]        v_q;
	logic [LW-1:0]        lv_q;
	logic [CW-1:0]        p_q;
	logic [NW:0]          depth_q;
	logic [NW:0]          qh_q;
	logic [NW:0]          qt_q;
	logic [NW-1:0]        i_q;
	logic [AW-1:0]        a_q;
	logic [NW-1:0]        h_q;
	logic [CAP_WIDTH-1:0] d_q;
	logic                 out_valid_q;
	logic [FW-1:0]        out_flow_q;
	logic                 out_ovf_q;

	// Memory ports
	logic                 a_we, r_we, l_we, q_we, p_we, s_we;
	logic [AW-1:0]        a_wa, a_ra, r_wa, r_ra;
	logic [NW-1:0]        l_wa, l_ra, q_wa, q_ra, p_wa, p_ra, s_wa, s_ra;
	logic [2*NW-1:0]      a_wd, a_rd;
	logic [CAP_WIDTH-1:0] r_wd, r_rd;
	logic [LW-1:0]        l_wd, l_rd;
	logic [NW-1:0]        q_wd, q_rd;
	logic [CW-1:0]        p_wd, p_rd;
	logic [AW-1:0]        s_wd, s_rd;

	logic [NW-1:0]        s_node, t_node, u_node, w_node;
	logic [NW-1:0]        a_tail, a_head;
	logic                 in_fire, fits_now, arc_ok, usable, fresh;
	logic                 depth_full, i_last;
	logic [SW-1:0]        flow_sum;

	assign s_node   = NW'(src_node % MAX_NODES);
	assign t_node   = NW'(snk_node % MAX_NODES);
	assign u_node   = NW'(from_node % MAX_NODES);
	assign w_node   = NW'(to_node % MAX_NODES);
	assign a_tail   = a_rd[2*NW-1:NW];
	assign a_head   = a_rd[NW-1:0];
	assign in_fire  = in_valid && (cmd.op == mfd_pkg::OP_IDLE);
	assign fits_now = ((CW+1)'(cnt_q) + (CW+1)'(2)) <= (CW+1)'(SLOTS);
	assign arc_ok   = (a_tail == v_q) && (r_rd != '0);
	assign usable   = (l_rd != UNREACHED) && (lv_q < l_rd);
	assign fresh    = (l_rd == UNREACHED);
	assign depth_full = (depth_q == (NW+1)'(MAX_NODES));
	assign i_last   = ((NW+1)'(i_q) == depth_q - (NW+1)'(1));
	assign flow_sum = SW'(flow_q) + SW'(d_q);

	// Report status to the sequencer
	always_comb begin
		sts.in_fire    = in_fire;
		sts.last_q     = last_q;
		sts.st_eq      = (s_node == t_node);
		sts.sweep_last = (i_q == NW'(MAX_NODES - 1));
		sts.q_empty    = (qh_q == qt_q);
		sts.scan_end   = (p_q == cnt_q);
		sts.arc_ok     = arc_ok;
		sts.usable     = usable;
		sts.depth_full = depth_full;
		sts.depth_zero = (depth_q == '0);
		sts.t_unr      = fresh;
		sts.v_is_t     = (v_q == t_node);
		sts.i_last     = i_last;
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Steer memory ports by operation
	always_comb begin
		a_we = 1'b0; a_wa = cnt_q[AW-1:0]; a_wd = {u_node, w_node}; a_ra = p_q[AW-1:0];
		r_we = 1'b0; r_wa = cnt_q[AW-1:0]; r_wd = CAP_WIDTH'(capacity); r_ra = p_q[AW-1:0];
		l_we = 1'b0; l_wa = i_q; l_wd = UNREACHED; l_ra = v_q;
		q_we = 1'b0; q_wa = qt_q[NW-1:0]; q_wd = h_q; q_ra = qh_q[NW-1:0];
		p_we = 1'b0; p_wa = v_q; p_wd = p_q; p_ra = v_q;
		s_we = 1'b0; s_wa = depth_q[NW-1:0]; s_wd = p_q[AW-1:0]; s_ra = i_q;
		unique case (cmd.op)
			mfd_pkg::OP_IDLE: begin
				a_we = in_fire && fits_now;
				r_we = in_fire && fits_now;
			end
			mfd_pkg::OP_REV: begin
				a_we = fits_q;
				a_wa = AW'(cnt_q + CW'(1));
				a_wd = {ew_q, eu_q};
				r_we = fits_q;
				r_wa = AW'(cnt_q + CW'(1));
				r_wd = '0;
			end
			mfd_pkg::OP_LCLR: l_we = 1'b1;
			mfd_pkg::OP_LINIT: begin
				l_we = 1'b1; l_wa = s_node; l_wd = '0;
				q_we = 1'b1; q_wa = '0; q_wd = s_node;
			end
			mfd_pkg::OP_BQRD: l_ra = q_rd;
			mfd_pkg::OP_BARC, mfd_pkg::OP_DARC: l_ra = a_head;
			mfd_pkg::OP_BLW: begin
				l_we = fresh; l_wa = h_q; l_wd = lv_q + LW'(1);
				q_we = fresh && (qt_q < (NW+1)'(MAX_NODES));
			end
			mfd_pkg::OP_BDONE_RD: l_ra = t_node;
			mfd_pkg::OP_PCLR: begin
				p_we = 1'b1; p_wa = i_q; p_wd = '0;
			end
			mfd_pkg::OP_DLW: begin
				p_we = usable;
				s_we = usable && !depth_full;
			end
			mfd_pkg::OP_DMISS: p_we = 1'b1;
			mfd_pkg::OP_DPOP0: s_ra = NW'(depth_q - (NW+1)'(1));
			mfd_pkg::OP_DPOP1: a_ra = s_rd;
			mfd_pkg::OP_DPOP2: p_ra = a_tail;
			mfd_pkg::OP_DPOP3: begin
				p_we = 1'b1; p_wd = p_rd + CW'(1);
			end
			mfd_pkg::OP_AMIN_A, mfd_pkg::OP_AUP_A: r_ra = s_rd;
			mfd_pkg::OP_AUP_W: begin
				r_we = 1'b1; r_wa = a_q; r_wd = r_rd - d_q;
				r_ra = a_q ^ AW'(1);
			end
			mfd_pkg::OP_AUP_V: begin
				r_we = 1'b1; r_wa = a_q ^ AW'(1); r_wd = r_rd + d_q;
			end
			default: ;
		endcase
	end

	// Advance walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			flow_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			depth_q     <= '0;
			qh_q        <= '0;
			qt_q        <= '0;
			i_q         <= '0;
			fits_q      <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			// Drop the result once transferred
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			i_q <= '0;
			unique case (cmd.op)
				mfd_pkg::OP_IDLE: begin
					if (in_fire) begin
						fits_q <= fits_now;
						last_q <= last_edge;
						eu_q   <= u_node;
						ew_q   <= w_node;
						if (!fits_now) ovf_q <= 1'b1;
					end
				end
				mfd_pkg::OP_REV: if (fits_q) cnt_q <= cnt_q + CW'(2);
				mfd_pkg::OP_START: flow_q <= '0;
				mfd_pkg::OP_LCLR, mfd_pkg::OP_PCLR: i_q <= i_q + NW'(1);
				mfd_pkg::OP_LINIT: begin
					qh_q <= '0;
					qt_q <= (NW+1)'(1);
				end
				mfd_pkg::OP_BQRD: begin
					v_q  <= q_rd;
					qh_q <= qh_q + (NW+1)'(1);
					p_q  <= '0;
				end
				mfd_pkg::OP_BLV: lv_q <= l_rd;
				mfd_pkg::OP_BARC: begin
					p_q <= p_q + CW'(1);
					h_q <= a_head;
				end
				mfd_pkg::OP_BLW: begin
					if (fresh && (qt_q < (NW+1)'(MAX_NODES))) qt_q <= qt_q + (NW+1)'(1);
				end
				mfd_pkg::OP_DINIT: begin
					depth_q <= '0;
					v_q     <= s_node;
				end
				mfd_pkg::OP_DTOP: d_q <= '1;
				mfd_pkg::OP_DRD: begin
					p_q  <= p_rd;
					lv_q <= l_rd;
				end
				mfd_pkg::OP_DARC: begin
					h_q <= a_head;
					if (!arc_ok) p_q <= p_q + CW'(1);
				end
				mfd_pkg::OP_DLW: begin
					if (!usable) begin
						p_q <= p_q + CW'(1);
					end else if (!depth_full) begin
						depth_q <= depth_q + (NW+1)'(1);
						v_q     <= h_q;
					end
				end
				mfd_pkg::OP_DPOP0: depth_q <= depth_q - (NW+1)'(1);
				mfd_pkg::OP_DPOP2: v_q <= a_tail;
				mfd_pkg::OP_AMIN_S, mfd_pkg::OP_AMIN_A, mfd_pkg::OP_AUP_S,
				mfd_pkg::OP_AUP_W: i_q <= i_q;
				mfd_pkg::OP_AUP_A: begin
					i_q <= i_q;
					a_q <= s_rd;
				end
				mfd_pkg::OP_AMIN_R: begin
					if (r_rd < d_q) d_q <= r_rd;
					i_q <= i_last ? '0 : i_q + NW'(1);
				end
				mfd_pkg::OP_AUP_V: begin
					i_q <= i_last ? '0 : i_q + NW'(1);
					if (i_last) begin
						flow_q  <= (flow_sum > SW'(mfd_pkg::FLOW_MAX)) ?
							mfd_pkg::FLOW_MAX : flow_sum[FW-1:0];
						depth_q <= '0;
						v_q     <= s_node;
					end
				end
				default: ;
			endcase

			// Present the result and start a new graph
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				out_flow_q  <= (cmd.op == mfd_pkg::OP_START) ? '0 : flow_q;
				out_ovf_q   <= ovf_q;
				cnt_q       <= '0;
				flow_q      <= '0;
				ovf_q       <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign max_flow       = out_flow_q;
	assign table_overflow = out_ovf_q;

	mfd_ram #(.WIDTH(2*NW), .DEPTH(SLOTS)) u_arc_ram (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
	mfd_ram #(.WIDTH(CAP_WIDTH), .DEPTH(SLOTS)) u_res_ram (
		.clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
	mfd_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_lvl_ram (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
	mfd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_que_ram (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
	mfd_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_ptr_ram (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
	mfd_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_stk_ram (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

	// Arc table holds whole forward/reverse pairs and never overruns
	a_cnt_even: assert property (@(posedge clk) disable iff (!arst_n)
		!cnt_q[0] && (cnt_q <= CW'(SLOTS)))
		else $error("arc count odd or past table size");

	// Path stack stays within the node count
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= (NW+1)'(MAX_NODES))
		else $error("path stack overrun");

	// Queue head never passes its tail
	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		(qh_q <= qt_q) && (qt_q <= (NW+1)'(MAX_NODES)))
		else $error("level queue pointers out of order");

	// A new result is only loaded into a free output slot
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

endmodule

// ===== rtl/max_flow_dinic_core.sv =====
// Max-flow core: loads edges into a residual arc table, then runs Dinic's method.
// Loading: forward arc, then reverse arc; next edge taken after both; one graph at a time.
// Level pass: clear levels, then scan the arcs of each reached node. Blocking pass: clear
// pointers, then node visits, arc scans, retreats and augmentations; each memory read is
// registered. The result is valid in the cycle after the final step.
// Reset clears control and counters and sets source 0, sink 1; memories are not cleared.
module max_flow_dinic_core #(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 256,
	parameter int CAP_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mfd_pkg::CFG_AW-1:0]    paddr,
	input  logic [mfd_pkg::CFG_DW-1:0]    pwdata,
	output logic [mfd_pkg::CFG_DW-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mfd_pkg::NODE_W-1:0]    from_node,
	input  logic [mfd_pkg::NODE_W-1:0]    to_node,
	input  logic [mfd_pkg::IN_CAP_W-1:0]  capacity,
	input  logic                          last_edge,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mfd_pkg::FLOW_W-1:0]    max_flow,
	output logic                          table_overflow
);

	logic [mfd_pkg::NODE_W-1:0] src_q;
	logic [mfd_pkg::NODE_W-1:0] snk_q;
	mfd_pkg::cmd_t              cmd;
	mfd_pkg::status_t           sts;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= '0;
			snk_q <= mfd_pkg::NODE_W'(1);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == mfd_pkg::REG_SINK) snk_q <= pwdata[mfd_pkg::NODE_W-1:0];
			else src_q <= pwdata[mfd_pkg::NODE_W-1:0];
		end
	end

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == mfd_pkg::REG_SINK) ?
		mfd_pkg::CFG_DW'(snk_q) : mfd_pkg::CFG_DW'(src_q);
	assign in_ready = (cmd.op == mfd_pkg::OP_IDLE);

	mfd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	mfd_dp #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES),
		.CAP_WIDTH (CAP_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.src_node       (src_q),
		.snk_node       (snk_q),
		.in_valid       (in_valid),
		.from_node      (from_node),
		.to_node        (to_node),
		.capacity       (capacity),
		.last_edge      (last_edge),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.max_flow       (max_flow),
		.table_overflow (table_overflow)
	);

endmodule

// ===== verif/tb_top.sv =====
// Testbench for max_flow_dinic_core: streams edge lists and checks each max-flow result.
// Depends on mfd_pkg and the RTL; a built-in Dinic predictor supplies expected results.
`timescale 1ns / 100ps

module tb_top;

	typedef struct {
		logic [mfd_pkg::NODE_W-1:0]   tail_n;
		logic [mfd_pkg::NODE_W-1:0]   head_n;
		logic [mfd_pkg::IN_CAP_W-1:0] cap;
		logic                         last;
	} edge_item_t;

	typedef struct {
		logic [mfd_pkg::FLOW_W-1:0] flow;
		logic                       ovf;
	} flow_result_t;

	localparam int NODES     = 64;
	localparam int ARC_SLOTS = 512;
	localparam int NO_LEVEL  = 127;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [mfd_pkg::CFG_AW-1:0] paddr;
	logic [mfd_pkg::CFG_DW-1:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [mfd_pkg::NODE_W-1:0] from_node, to_node;
	logic [mfd_pkg::IN_CAP_W-1:0] capacity;
	logic last_edge;
	logic out_valid, out_ready;
	logic [mfd_pkg::FLOW_W-1:0] max_flow;
	logic table_overflow;

	max_flow_dinic_core dut (.*);

	edge_item_t   edge_q[$];
	flow_result_t flow_expect_q[$];
	int mismatches = 0;
	int idle_mode = 0;
	int items_sent = 0;

	// Mirror of the block's registers and graph store
	int src_reg = 0, snk_reg = 1;
	bit [5:0] a_tail[ARC_SLOTS], a_head[ARC_SLOTS];
	longint unsigned a_res[ARC_SLOTS];
	int n_arcs = 0;
	bit table_full = 0;
	int lvl[NODES], arc_ptr[NODES], bfs_q[NODES], path_stk[NODES];
	logic [mfd_pkg::FLOW_W:0] flow_sum;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Breadth-first level assignment from s
	function automatic void assign_levels(int s);
		int qh, qt, v, w;
		qh = 0; qt = 0;
		for (int i = 0; i < NODES; i++) lvl[i] = NO_LEVEL;
		lvl[s] = 0;
		bfs_q[qt++] = s;
		while (qh < qt) begin
			v = bfs_q[qh++];
			for (int i = 0; i < n_arcs; i++) begin
				w = a_head[i];
				if (a_tail[i] == v && a_res[i] != 0 && lvl[w] == NO_LEVEL) begin
					lvl[w] = lvl[v] + 1;
					if (qt < NODES) bfs_q[qt++] = w;
				end
			end
		end
	endfunction

	function automatic bit arc_open(int a, int v);
		int w;
		w = a_head[a];
		return a_tail[a] == v && a_res[a] > 0 && lvl[w] != NO_LEVEL && lvl[v] < lvl[w];
	endfunction

	// Push blocking flow along the level graph with an explicit path stack
	function automatic void push_blocking(int s, int t);
		int depth, v, p, a;
		longint unsigned d;
		depth = 0;
		for (int i = 0; i < NODES; i++) arc_ptr[i] = 0;
		while (1) begin
			v = (depth == 0) ? s : a_head[path_stk[depth-1]];
			if (v == t) begin
				d = '1;
				for (int i = 0; i < depth; i++)
					if (a_res[path_stk[i]] < d) d = a_res[path_stk[i]];
				for (int i = 0; i < depth; i++) begin
					a_res[path_stk[i]] -= d;
					a_res[path_stk[i] ^ 1] += d;
				end
				flow_sum = flow_sum + d;
				if (flow_sum > {1'b0, mfd_pkg::FLOW_MAX}) flow_sum = {1'b0, mfd_pkg::FLOW_MAX};
				depth = 0;
				continue;
			end
			p = arc_ptr[v];
			while (p < n_arcs && !arc_open(p, v)) p++;
			arc_ptr[v] = p;
			if (p < n_arcs && depth < NODES) begin
				path_stk[depth++] = p;
			end else begin
				if (depth == 0) return;
				a = path_stk[--depth];
				arc_ptr[a_tail[a]]++;
			end
		end
	endfunction

	// Store one edge; on the last edge compute the flow and queue the result
	function automatic void accept_edge(edge_item_t e);
		flow_result_t r;
		if (n_arcs + 2 <= ARC_SLOTS) begin
			a_tail[n_arcs] = e.tail_n; a_head[n_arcs] = e.head_n; a_res[n_arcs] = e.cap;
			a_tail[n_arcs+1] = e.head_n; a_head[n_arcs+1] = e.tail_n; a_res[n_arcs+1] = 0;
			n_arcs += 2;
		end else begin
			table_full = 1;
		end
		if (!e.last) return;
		flow_sum = 0;
		if (src_reg != snk_reg) begin
			while (1) begin
				assign_levels(src_reg);
				if (lvl[snk_reg] == NO_LEVEL) break;
				push_blocking(src_reg, snk_reg);
			end
		end
		r.flow = flow_sum[mfd_pkg::FLOW_W-1:0];
		r.ovf = table_full;
		flow_expect_q.insert(flow_expect_q.size(), r);
		n_arcs = 0;
		table_full = 0;
	endfunction

	// Edge driver: advance after each transfer, idle at random per mode
	always @(posedge clk or negedge arst_n) begin
		edge_item_t nx;
		int idle_pct;
		if (!arst_n) begin
			in_valid <= 1'b0;
			from_node <= '0; to_node <= '0; capacity <= '0; last_edge <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				accept_edge('{from_node, to_node, capacity, last_edge});
			idle_pct = (idle_mode == 1) ? 49 : (idle_mode == 3) ? 7 : 0;
			if (edge_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
				nx = edge_q.pop_front();
				in_valid <= 1'b1;
				from_node <= nx.tail_n; to_node <= nx.head_n;
				capacity <= nx.cap; last_edge <= nx.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		flow_result_t ex;
		int stall_pct;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (flow_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: max_flow=%0d overflow=%0b",
							max_flow, table_overflow);
				end else begin
					ex = flow_expect_q.pop_front();
					if (max_flow !== ex.flow || table_overflow !== ex.ovf) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: max_flow exp %0d got %0d, overflow exp %0b got %0b",
								ex.flow, max_flow, ex.ovf, table_overflow);
					end
				end
			end
			stall_pct = (idle_mode == 2) ? 49 : (idle_mode == 3) ? 7 : 0;
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic add_edge(int t, int h, logic [31:0] c, bit l);
		edge_item_t e;
		e = '{t[5:0], h[5:0], c, l};
		edge_q.insert(edge_q.size(), e);
		items_sent++;
	endtask

	// Hold until every edge is transferred and every result has come back
	task automatic drain();
		while (edge_q.size() > 0 || in_valid || flow_expect_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(logic idx, int val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == mfd_pkg::REG_SOURCE) src_reg = val & 63;
		else snk_reg = val & 63;
	endtask

	task automatic new_phase(int s, int t, int mode);
		drain();
		reg_write(mfd_pkg::REG_SOURCE, s);
		reg_write(mfd_pkg::REG_SINK, t);
		idle_mode = mode;
	endtask

	function automatic int pick_node(int span);
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, span);
	endfunction

	function automatic logic [31:0] pick_cap();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 20);
			1: return $urandom;
			2: return 32'hFFFF_FFFF;
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	initial begin
		int n;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme capacities, parallel and reverse paths, self-loop
		new_phase(0, 1, 0);
		add_edge(0, 1, 32'hFFFF_FFFF, 0);
		add_edge(0, 1, 32'hFFFF_FFFF, 0);
		add_edge(1, 1, 55, 0);
		add_edge(0, 2, 0, 1);
		add_edge(0, 2, 10, 0);
		add_edge(2, 3, 4, 0);
		add_edge(3, 1, 9, 0);
		add_edge(2, 1, 3, 0);
		add_edge(0, 3, 6, 1);
		// Sink unreachable
		add_edge(1, 0, 100, 1);

		// Top node indices, sender idling
		new_phase(63, 0, 1);
		add_edge(63, 0, 32'h8000_0000, 0);
		add_edge(63, 62, 7, 0);
		add_edge(62, 0, 32'h7FFF_FFFF, 1);
		add_edge(0, 63, 1, 1);

		// Source equal to sink
		new_phase(5, 5, 2);
		add_edge(5, 6, 8, 0);
		add_edge(6, 5, 8, 1);

		// Full table: one useful edge, filler past the table size, a dropped last edge, then a fresh graph
		new_phase(0, 63, 3);
		add_edge(0, 63, 12345, 0);
		for (int i = 0; i < 256; i++) add_edge(5, 6, $urandom, 0);
		add_edge(0, 63, 999, 1);
		add_edge(0, 63, 77, 1);

		// Random graphs over a spread of register settings and idle modes
		n = 0;
		while (items_sent < 1550) begin
			new_phase($urandom_range(0, 7), $urandom_range(0, 7), n % 4);
			if (n % 5 == 4) begin
				reg_write(mfd_pkg::REG_SOURCE, 63);
				reg_write(mfd_pkg::REG_SINK, $urandom_range(0, 1) ? 0 : 63);
			end
			repeat (10) begin
				int k;
				k = $urandom_range(1, 20);
				for (int i = 0; i < k; i++)
					add_edge(pick_node(7), pick_node(7), pick_cap(), i == k - 1);
			end
			n++;
		end

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("max_flow_dinic_core verification clean");
		end else begin
			$display("max_flow_dinic_core verification failed");
		end
		$finish;
	end

	// Run limit
	initial begin
		#200_000_000;
		$display("max_flow_dinic_core verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mfd_pkg.sv
rtl/mfd_ram.sv
rtl/mfd_ctrl.sv
rtl/mfd_dp.sv
rtl/max_flow_dinic_core.sv
verif/tb_top.sv
